// ===== rtl/ngga_pkg.sv =====
// ----------------------------------------------------------------------------
// ngga_pkg
// shared constants, lookup functions and interface structs of the gga parser
// ----------------------------------------------------------------------------
package ngga_pkg;

    localparam int LINE_LIMIT_DEF      = 127;
    localparam int MIN_FRAC_DIGITS_DEF = 5;

    // number accumulators
    localparam int ACC_W      = 24;
    localparam int FRAC_MAX_W = 20;
    localparam int CNT_W      = 3;
    localparam int MAG_W      = 31;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // field numbers after the sentence prefix
    localparam int FIELD_W = 4;
    localparam logic [FIELD_W-1:0] FLD_LAT  = 4'd1;
    localparam logic [FIELD_W-1:0] FLD_NS   = 4'd2;
    localparam logic [FIELD_W-1:0] FLD_LON  = 4'd3;
    localparam logic [FIELD_W-1:0] FLD_EW   = 4'd4;
    localparam logic [FIELD_W-1:0] FLD_FIX  = 4'd5;
    localparam logic [FIELD_W-1:0] FLD_ALT  = 4'd8;
    localparam logic [FIELD_W-1:0] FLD_LAST = 4'd9;

    // prefix matcher
    localparam logic [2:0] PREFIX_ALT_POS = 3'd2;
    localparam logic [2:0] PREFIX_DONE    = 3'd7;

    // characters
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_W      = 8'h57;

    // reciprocal constants: exact floor division for the ranges used
    localparam logic [24:0] DIV100_MULT  = 25'd21474837;   // ceil(2^31 / 100)
    localparam int          DIV100_SHIFT = 31;
    localparam logic [27:0] DIV6_MULT    = 28'd178956971;  // ceil(2^30 / 6)
    localparam int          DIV6_SHIFT   = 30;
    localparam logic [19:0] E6           = 20'd1000000;
    localparam logic [23:0] E7           = 24'd10000000;
    localparam logic [6:0]  HUNDRED      = 7'd100;

    typedef struct packed {
        logic                  valid;
        logic                  is_lon;
        logic [ACC_W-1:0]      int_val;
        logic [FRAC_MAX_W-1:0] frac;
        logic [CNT_W-1:0]      frac_cnt;
    } angle_req_t;

    typedef struct packed {
        logic             fire;
        logic             lat_neg;
        logic             lon_neg;
        logic             alt_neg;
        logic [MAG_W-1:0] alt_mag;
    } fix_emit_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CHAR_DOLLAR;
            3'd1:    ch = CHAR_G;
            3'd2:    ch = CHAR_P;
            3'd3:    ch = CHAR_G;
            3'd4:    ch = CHAR_G;
            3'd5:    ch = CHAR_A;
            default: ch = CHAR_COMMA;
        endcase
        return ch;
    endfunction

    // 10^(6 - cnt): brings a fraction of cnt digits to millionths
    function automatic logic [FRAC_MAX_W-1:0] frac_scale(input logic [CNT_W-1:0] cnt);
        logic [FRAC_MAX_W-1:0] s;
        case (cnt)
            3'd0:    s = 20'd1000000;
            3'd1:    s = 20'd100000;
            3'd2:    s = 20'd10000;
            3'd3:    s = 20'd1000;
            3'd4:    s = 20'd100;
            3'd5:    s = 20'd10;
            3'd6:    s = 20'd1;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/nmea_gga_fix_parser_core.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_fix_parser_core
// throughput: one received byte per cycle, stalled while a fix waits unread
// a fix is on m_ in the cycle after its terminating cr or lf is taken
// coordinates go through a six-stage conversion pipeline that ends
// before the shortest possible remainder of a line has arrived
// reset: synchronous active-low aresetn clears parser state and m_valid
// ----------------------------------------------------------------------------
module nmea_gga_fix_parser_core
    import ngga_pkg::*;
#(
    parameter int LINE_LIMIT         = LINE_LIMIT_DEF,
    parameter int MINUTE_FRAC_DIGITS = MIN_FRAC_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // received byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // fix results
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_lat_e7,
    output logic signed [31:0] m_lon_e7,
    output logic signed [31:0] m_alt_cm
);

    // largest altitude magnitude: saturated integer part times 100 plus 99
    localparam logic signed [31:0] ALT_ABS_MAX = 32'sd1677721599;

    logic       accept;
    angle_req_t angle_req;
    fix_emit_t  emit;

    logic [MAG_W-1:0] lat_mag;
    logic [MAG_W-1:0] lon_mag;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] lat_reg, lat_next;
    logic [31:0] lon_reg, lon_next;
    logic [31:0] alt_reg, alt_next;

    // the output register frees itself in the same cycle it is read, so a
    // new word can be accepted on every clock while the sink keeps up
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // byte-level line parser: prefix, field counter, digit accumulators
    ngga_lexer #(
        .LINE_LIMIT         (LINE_LIMIT),
        .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .angle_req (angle_req),
        .emit      (emit)
    );

    // latitude / longitude magnitude pipeline, holds the last value of each
    ngga_angle_conv u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (angle_req),
        .lat_mag (lat_mag),
        .lon_mag (lon_mag)
    );

    // sign is applied last: magnitudes are already clamped to 2^31-1,
    // so the negated value never reaches the most negative code
    always_comb begin
        m_valid_next = m_valid_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        alt_next     = alt_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit.fire) begin
            m_valid_next = 1'b1;
            lat_next = emit.lat_neg ? (32'd0 - {1'b0, lat_mag}) : {1'b0, lat_mag};
            lon_next = emit.lon_neg ? (32'd0 - {1'b0, lon_mag}) : {1'b0, lon_mag};
            alt_next = emit.alt_neg ? (32'd0 - {1'b0, emit.alt_mag})
                                    : {1'b0, emit.alt_mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only when a line completes
    always_ff @(posedge aclk) begin
        lat_reg <= lat_next;
        lon_reg <= lon_next;
        alt_reg <= alt_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_lat_e7 = $signed(lat_reg);
    assign m_lon_e7 = $signed(lon_reg);
    assign m_alt_cm = $signed(alt_reg);

`ifndef SYNTHESIS
    // a fix is only ever produced by an accepted line terminator
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.fire |-> (accept && (s_rx_byte == CHAR_CR || s_rx_byte == CHAR_LF)))
        else $error("fix emitted on a non-terminator word");

    // saturation keeps coordinates off the most negative code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lat_e7 != 32'sh8000_0000 && m_lon_e7 != 32'sh8000_0000))
        else $error("coordinate outside saturated range");

    // altitude magnitude is bounded by the accumulator saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_alt_cm <= ALT_ABS_MAX && m_alt_cm >= -ALT_ABS_MAX))
        else $error("altitude outside accumulator range");

    // input side is only held off while a fix is waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with free output register");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

// ===== rtl/ngga_lexer.sv =====
// ----------------------------------------------------------------------------
// ngga_lexer
// per-byte line, prefix, field and number tracking of gga sentences
// ----------------------------------------------------------------------------
module ngga_lexer
    import ngga_pkg::*;
#(
    parameter int LINE_LIMIT         = LINE_LIMIT_DEF,
    parameter int MINUTE_FRAC_DIGITS = MIN_FRAC_DIGITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output angle_req_t angle_req,
    output fix_emit_t  emit
);

    localparam int LC_W   = $clog2(LINE_LIMIT);
    localparam int FRAC_W = $clog2(10 ** MINUTE_FRAC_DIGITS);
    localparam logic [CNT_W-1:0] KEEP_ANGLE = CNT_W'(MINUTE_FRAC_DIGITS);
    localparam logic [CNT_W-1:0] KEEP_ALT   = CNT_W'(2);
    localparam logic [LC_W:0]    LIMIT      = (LC_W + 1)'(LINE_LIMIT);

    logic [LC_W-1:0]    line_count_reg, line_count_next;
    logic [2:0]         prefix_pos_reg, prefix_pos_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic               line_bad_reg, line_bad_next;
    logic [ACC_W-1:0]   int_acc_reg, int_acc_next;
    logic [FRAC_W-1:0]  frac_acc_reg, frac_acc_next;
    logic [CNT_W-1:0]   frac_cnt_reg, frac_cnt_next;
    logic               val_neg_reg, val_neg_next;
    logic               digit_seen_reg, digit_seen_next;
    logic               point_seen_reg, point_seen_next;
    logic               started_reg, started_next;
    logic               lat_neg_reg, lat_neg_next;
    logic               lon_neg_reg, lon_neg_next;
    logic               alt_neg_reg, alt_neg_next;
    logic [MAG_W-1:0]   alt_mag_reg, alt_mag_next;

    logic               is_term;
    logic               is_digit;
    logic               numeric;
    logic               bad;
    logic               clear_line;
    logic               clear_num;
    logic [LC_W:0]      lc_inc;
    logic [CNT_W-1:0]   keep;
    logic [3:0]         digit;
    logic [ACC_W+3:0]   int_grow;
    logic [FRAC_W-1:0]  frac_grow;
    logic [6:0]         alt_frac;
    logic [MAG_W-1:0]   alt_now;

    always_comb begin
        is_term   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
        is_digit  = rx_byte inside {[CHAR_0:CHAR_9]};
        numeric   = (field_reg == FLD_LAT) || (field_reg == FLD_LON) ||
                    (field_reg == FLD_FIX) || (field_reg == FLD_ALT);
        keep      = (field_reg == FLD_ALT) ? KEEP_ALT : KEEP_ANGLE;
        digit     = 4'(rx_byte - CHAR_0);
        lc_inc    = {1'b0, line_count_reg} + 1'b1;
        int_grow  = {1'b0, int_acc_reg, 3'b000} + {3'b000, int_acc_reg, 1'b0} +
                    (ACC_W + 4)'(digit);
        frac_grow = FRAC_W'(frac_acc_reg * FRAC_W'(10) + FRAC_W'(digit));

        // altitude in centimetres, truncated to two fraction digits
        case (frac_cnt_reg)
            3'd0:    alt_frac = '0;
            3'd1:    alt_frac = 7'(frac_acc_reg[6:0] * 7'd10);
            default: alt_frac = frac_acc_reg[6:0];
        endcase
        alt_now = MAG_W'({int_acc_reg, 6'b0}) + MAG_W'({int_acc_reg, 5'b0}) +
                  MAG_W'({int_acc_reg, 2'b0}) + MAG_W'(alt_frac);

        line_count_next = line_count_reg;
        prefix_pos_next = prefix_pos_reg;
        field_next      = field_reg;
        int_acc_next    = int_acc_reg;
        frac_acc_next   = frac_acc_reg;
        frac_cnt_next   = frac_cnt_reg;
        val_neg_next    = val_neg_reg;
        digit_seen_next = digit_seen_reg;
        point_seen_next = point_seen_reg;
        started_next    = started_reg;
        lat_neg_next    = lat_neg_reg;
        lon_neg_next    = lon_neg_reg;
        alt_neg_next    = alt_neg_reg;
        alt_mag_next    = alt_mag_reg;
        bad             = line_bad_reg;
        clear_line      = 1'b0;
        clear_num       = 1'b0;

        angle_req          = '0;
        angle_req.is_lon   = (field_reg == FLD_LON);
        angle_req.int_val  = int_acc_reg;
        angle_req.frac     = FRAC_MAX_W'(frac_acc_reg);
        angle_req.frac_cnt = frac_cnt_reg;

        emit         = '0;
        emit.lat_neg = lat_neg_reg;
        emit.lon_neg = lon_neg_reg;
        if (field_reg == FLD_ALT) begin
            emit.alt_mag = alt_now;
            emit.alt_neg = val_neg_reg;
        end else begin
            emit.alt_mag = alt_mag_reg;
            emit.alt_neg = alt_neg_reg;
        end

        if (accept) begin
            if (is_term) begin
                if (line_count_reg != '0) begin
                    if (!line_bad_reg && prefix_pos_reg == PREFIX_DONE) begin
                        if (field_reg == FLD_LAST ||
                            (field_reg == FLD_ALT && digit_seen_reg)) begin
                            emit.fire = 1'b1;
                        end
                    end
                    clear_line = 1'b1;
                end
            end else begin
                line_count_next = lc_inc[LC_W-1:0];
                if (rx_byte == CHAR_NUL) begin
                    bad = 1'b1;
                end
                if (!bad) begin
                    if (prefix_pos_reg != PREFIX_DONE) begin
                        if (rx_byte == prefix_char(prefix_pos_reg) ||
                            (prefix_pos_reg == PREFIX_ALT_POS && rx_byte == CHAR_N)) begin
                            prefix_pos_next = prefix_pos_reg + 3'd1;
                        end else begin
                            bad = 1'b1;
                        end
                    end else if (rx_byte == CHAR_COMMA) begin
                        // close the current field
                        if (numeric && !digit_seen_reg) begin
                            bad = 1'b1;
                        end else if (field_reg == FLD_LAT) begin
                            angle_req.valid = 1'b1;
                            lat_neg_next    = val_neg_reg;
                        end else if (field_reg == FLD_LON) begin
                            angle_req.valid = 1'b1;
                            lon_neg_next    = val_neg_reg;
                        end else if (field_reg == FLD_FIX) begin
                            if (int_acc_reg == '0) begin
                                bad = 1'b1;
                            end
                        end else if (field_reg == FLD_ALT) begin
                            alt_mag_next = alt_now;
                            alt_neg_next = val_neg_reg;
                        end
                        if (field_reg != FLD_LAST) begin
                            field_next = field_reg + 4'd1;
                        end
                        clear_num = 1'b1;
                    end else begin
                        if (numeric) begin
                            if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
                                if (started_reg || field_reg == FLD_FIX) begin
                                    bad = 1'b1;
                                end else begin
                                    val_neg_next = (rx_byte == CHAR_MINUS);
                                end
                            end else if (rx_byte == CHAR_DOT) begin
                                if (point_seen_reg || field_reg == FLD_FIX) begin
                                    bad = 1'b1;
                                end else begin
                                    point_seen_next = 1'b1;
                                end
                            end else if (is_digit) begin
                                digit_seen_next = 1'b1;
                                if (!point_seen_reg) begin
                                    if (int_grow > (ACC_W + 4)'(ACC_MAX)) begin
                                        int_acc_next = ACC_MAX;
                                    end else begin
                                        int_acc_next = int_grow[ACC_W-1:0];
                                    end
                                end else if (frac_cnt_reg < keep) begin
                                    frac_acc_next = frac_grow;
                                    frac_cnt_next = frac_cnt_reg + 3'd1;
                                end
                            end else begin
                                bad = 1'b1;
                            end
                        end else if (!started_reg) begin
                            // hemisphere: first character only
                            if (field_reg == FLD_NS && rx_byte == CHAR_S) begin
                                lat_neg_next = !lat_neg_reg;
                            end else if (field_reg == FLD_EW && rx_byte == CHAR_W) begin
                                lon_neg_next = !lon_neg_reg;
                            end
                        end
                        started_next = 1'b1;
                    end
                end
                if (lc_inc >= LIMIT) begin
                    clear_line = 1'b1;
                end
            end
        end

        line_bad_next = bad;
        if (clear_num || clear_line) begin
            int_acc_next    = '0;
            frac_acc_next   = '0;
            frac_cnt_next   = '0;
            val_neg_next    = 1'b0;
            digit_seen_next = 1'b0;
            point_seen_next = 1'b0;
            started_next    = 1'b0;
        end
        if (clear_line) begin
            line_count_next = '0;
            prefix_pos_next = '0;
            field_next      = '0;
            line_bad_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= '0;
            prefix_pos_reg <= '0;
            field_reg      <= '0;
            line_bad_reg   <= 1'b0;
            int_acc_reg    <= '0;
            frac_acc_reg   <= '0;
            frac_cnt_reg   <= '0;
            val_neg_reg    <= 1'b0;
            digit_seen_reg <= 1'b0;
            point_seen_reg <= 1'b0;
            started_reg    <= 1'b0;
            lat_neg_reg    <= 1'b0;
            lon_neg_reg    <= 1'b0;
            alt_neg_reg    <= 1'b0;
            alt_mag_reg    <= '0;
        end else begin
            line_count_reg <= line_count_next;
            prefix_pos_reg <= prefix_pos_next;
            field_reg      <= field_next;
            line_bad_reg   <= line_bad_next;
            int_acc_reg    <= int_acc_next;
            frac_acc_reg   <= frac_acc_next;
            frac_cnt_reg   <= frac_cnt_next;
            val_neg_reg    <= val_neg_next;
            digit_seen_reg <= digit_seen_next;
            point_seen_reg <= point_seen_next;
            started_reg    <= started_next;
            lat_neg_reg    <= lat_neg_next;
            lon_neg_reg    <= lon_neg_next;
            alt_neg_reg    <= alt_neg_next;
            alt_mag_reg    <= alt_mag_next;
        end
    end

endmodule

// ===== rtl/ngga_angle_conv.sv =====
// ----------------------------------------------------------------------------
// ngga_angle_conv
// pipelined ddmm.mmmm to degrees*1e7 conversion with saturation
// ----------------------------------------------------------------------------
module ngga_angle_conv
    import ngga_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  angle_req_t       req,
    output logic [MAG_W-1:0] lat_mag,
    output logic [MAG_W-1:0] lon_mag
);

    logic [5:1] vld_reg;
    logic [5:1] lon_reg;

    logic [ACC_W-1:0]      s1_int_reg;
    logic [FRAC_MAX_W-1:0] s1_fs_reg;
    logic [ACC_W-1:0]      s2_int_reg;
    logic [FRAC_MAX_W-1:0] s2_fs_reg;
    logic [48:0]           s2_prod_reg;
    logic [17:0]           s3_deg_reg;
    logic [6:0]            s3_min_reg;
    logic [FRAC_MAX_W-1:0] s3_fs_reg;
    logic [26:0]           s4_x_reg;
    logic [40:0]           s4_dege7_reg;
    logic [54:0]           s5_prod_reg;
    logic [40:0]           s5_dege7_reg;
    logic [MAG_W-1:0]      lat_mag_reg;
    logic [MAG_W-1:0]      lon_mag_reg;

    logic [17:0]      deg2;
    logic [ACC_W-1:0] min_wide;
    logic [40:0]      sum6;
    logic [MAG_W-1:0] mag6;

    always_comb begin
        deg2     = s2_prod_reg[48:DIV100_SHIFT];
        min_wide = s2_int_reg - ACC_W'(deg2 * HUNDRED);
        sum6     = s5_dege7_reg + 41'(s5_prod_reg[54:DIV6_SHIFT]);
        mag6     = (sum6 > 41'(MAG_MAX)) ? MAG_MAX : sum6[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            lon_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[4:1], req.valid};
            lon_reg <= {lon_reg[4:1], req.is_lon};
        end
    end

    always_ff @(posedge aclk) begin
        // stage 1: fraction to millionths of a minute
        s1_int_reg   <= req.int_val;
        s1_fs_reg    <= FRAC_MAX_W'(req.frac * frac_scale(req.frac_cnt));
        // stage 2: integer part over 100
        s2_int_reg   <= s1_int_reg;
        s2_fs_reg    <= s1_fs_reg;
        s2_prod_reg  <= 49'(s1_int_reg) * 49'(DIV100_MULT);
        // stage 3: degrees and whole minutes
        s3_deg_reg   <= deg2;
        s3_min_reg   <= min_wide[6:0];
        s3_fs_reg    <= s2_fs_reg;
        // stage 4: minutes in millionths, degrees scaled
        s4_x_reg     <= 27'(s3_min_reg * E6) + 27'(s3_fs_reg);
        s4_dege7_reg <= 41'(s3_deg_reg) * 41'(E7);
        // stage 5: minutes over 6
        s5_prod_reg  <= 55'(s4_x_reg) * 55'(DIV6_MULT);
        s5_dege7_reg <= s4_dege7_reg;
        // stage 6: sum and saturate
        if (vld_reg[5] && !lon_reg[5]) begin
            lat_mag_reg <= mag6;
        end
        if (vld_reg[5] && lon_reg[5]) begin
            lon_mag_reg <= mag6;
        end
    end

    assign lat_mag = lat_mag_reg;
    assign lon_mag = lon_mag_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// feeds nmea byte streams into the gga fix parser and checks every fix it
// emits against a cycle-free software parser kept in step with the input, or a typed fix
// ----------------------------------------------------------------------------
module tb_top;
    import ngga_pkg::*;

    localparam int          LINE_MAX     = LINE_LIMIT_DEF;
    localparam int          MIN_DIGITS   = MIN_FRAC_DIGITS_DEF;
    localparam longint unsigned MINUTE_SCALE = 64'd100000;   // 10^MIN_DIGITS
    localparam longint unsigned SAT_MAG      = 64'd2147483647;
    localparam logic [55:0] GGA_HEAD     = "$GPGGA,";
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RAND_BYTES   = 650;
    localparam int          RAND_FIXES   = 40;

    typedef struct packed {
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
    } gga_fix_t;

    // one directed line: junk bytes ahead of it, an optional nul and,
    // where it is obvious, the fix typed in by hand
    typedef struct {
        string    text;
        int       pad;
        int       nul_at;
        bit       typed;
        bit       gives_fix;
        gga_fix_t fix;
    } gga_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic signed [31:0] m_lat_e7;
    logic signed [31:0] m_lon_e7;
    logic signed [31:0] m_alt_cm;

    nmea_gga_fix_parser_core #(
        .LINE_LIMIT         (LINE_MAX),
        .MINUTE_FRAC_DIGITS (MIN_DIGITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_lat_e7  (m_lat_e7),
        .m_lon_e7  (m_lon_e7),
        .m_alt_cm  (m_alt_cm)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // software copy of the parser state
    // ------------------------------------------------------------------
    int                 line_len;
    logic [2:0]         prefix_hits;
    logic [3:0]         field_idx;
    logic               line_rejected;
    logic [23:0]        int_digits;
    logic [16:0]        frac_digits;
    logic [2:0]         frac_count;
    logic               minus_seen;
    logic signed [31:0] lat_hold;
    logic signed [31:0] lon_hold;
    logic signed [31:0] alt_hold;
    logic               digit_seen;
    logic               point_seen;
    logic               field_open;

    gga_fix_t   pending_fixes[$];
    int         fixes_made;
    int         fail_count;
    int         bytes_sent;

    // directed rows with a hand-typed fix override the software parser
    bit         row_typed;
    bit         row_gives_fix;
    gga_fix_t   row_fix;

    // idling on both sides, and the long drain hold-off request
    bit         gaps_on;
    bit         hold_req;

    logic [7:0] line_buf[$];

    function void clear_number();
        int_digits  = '0;
        frac_digits = '0;
        frac_count  = '0;
        minus_seen  = 1'b0;
        digit_seen  = 1'b0;
        point_seen  = 1'b0;
        field_open  = 1'b0;
    endfunction

    function void clear_line();
        line_len      = 0;
        prefix_hits   = '0;
        field_idx     = '0;
        line_rejected = 1'b0;
        clear_number();
    endfunction

    function automatic bit is_number_field(input logic [3:0] f);
        return f == FLD_LAT || f == FLD_LON || f == FLD_FIX || f == FLD_ALT;
    endfunction

    // clamp a magnitude to 31 bits, then apply the sign
    function automatic logic signed [31:0] sat_signed(input longint unsigned mag,
                                                      input logic neg);
        logic signed [31:0] v;
        if (mag > SAT_MAG)
            mag = SAT_MAG;
        v = mag[31:0];
        return neg ? -v : v;
    endfunction

    // ddmm.mmmmm in the accumulators -> degrees * 1e7, truncated
    function logic signed [31:0] angle_e7();
        longint unsigned deg;
        longint unsigned mins;
        longint unsigned frac_scaled;
        longint unsigned min_units;
        int              k;
        deg         = int_digits / 100;
        mins        = int_digits % 100;
        frac_scaled = frac_digits;
        for (k = frac_count; k < MIN_DIGITS; k++)
            frac_scaled = frac_scaled * 10;
        min_units = mins * MINUTE_SCALE + frac_scaled;
        return sat_signed(deg * 64'd10000000 + (min_units * 64'd10000000) / (60 * MINUTE_SCALE),
                          minus_seen);
    endfunction

    // a comma or a terminator closes the current field
    function void close_field();
        longint unsigned cm;
        if (is_number_field(field_idx) && !digit_seen) begin
            line_rejected = 1'b1;
        end else if (field_idx == FLD_LAT) begin
            lat_hold = angle_e7();
        end else if (field_idx == FLD_LON) begin
            lon_hold = angle_e7();
        end else if (field_idx == FLD_FIX) begin
            if (int_digits == 0)
                line_rejected = 1'b1;
        end else if (field_idx == FLD_ALT) begin
            if (frac_count == 0)
                cm = 0;
            else if (frac_count == 1)
                cm = frac_digits * 10;
            else
                cm = frac_digits;
            alt_hold = sat_signed(longint'(int_digits) * 100 + cm, minus_seen);
        end
    endfunction

    // advance the parser by one byte, report the fix it completes if any
    function void parse_rx_byte(input logic [7:0] c, output bit made, output gga_fix_t fx);
        logic [2:0]      keep;
        longint unsigned wide;
        made = 1'b0;
        fx   = '0;
        if (c == CHAR_CR || c == CHAR_LF) begin
            if (line_len != 0) begin
                if (!line_rejected && prefix_hits == PREFIX_DONE) begin
                    close_field();
                    if (!line_rejected && field_idx >= FLD_ALT) begin
                        made = 1'b1;
                        fx   = '{lat_hold, lon_hold, alt_hold};
                    end
                end
                clear_line();
            end
        end else begin
            line_len++;
            if (c == CHAR_NUL)
                line_rejected = 1'b1;
            if (!line_rejected) begin
                if (prefix_hits != PREFIX_DONE) begin
                    // third prefix character may be p or n
                    if (c == GGA_HEAD[8 * (6 - int'(prefix_hits)) +: 8] ||
                        (prefix_hits == PREFIX_ALT_POS && c == CHAR_N))
                        prefix_hits++;
                    else
                        line_rejected = 1'b1;
                end else if (c == CHAR_COMMA) begin
                    close_field();
                    if (field_idx < FLD_LAST)
                        field_idx++;
                    clear_number();
                end else begin
                    if (is_number_field(field_idx)) begin
                        keep = (field_idx == FLD_ALT) ? 3'd2 : 3'(MIN_DIGITS);
                        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                            if (field_open || field_idx == FLD_FIX)
                                line_rejected = 1'b1;
                            else
                                minus_seen = (c == CHAR_MINUS);
                        end else if (c == CHAR_DOT) begin
                            if (point_seen || field_idx == FLD_FIX)
                                line_rejected = 1'b1;
                            else
                                point_seen = 1'b1;
                        end else if (c >= CHAR_0 && c <= CHAR_9) begin
                            digit_seen = 1'b1;
                            if (!point_seen) begin
                                wide = longint'(int_digits) * 10 + longint'(c - CHAR_0);
                                int_digits = (wide > ACC_MAX) ? ACC_MAX : wide[23:0];
                            end else if (frac_count < keep) begin
                                frac_digits = frac_digits * 10 + (c - CHAR_0);
                                frac_count++;
                            end
                        end else begin
                            line_rejected = 1'b1;
                        end
                    end else if (!field_open) begin
                        // only the first hemisphere letter counts
                        if (field_idx == FLD_NS && c == CHAR_S)
                            lat_hold = -lat_hold;
                        else if (field_idx == FLD_EW && c == CHAR_W)
                            lon_hold = -lon_hold;
                    end
                    field_open = 1'b1;
                end
            end
            // an over-long line is dropped and counting restarts
            if (line_len >= LINE_MAX)
                clear_line();
        end
    endfunction

    function void check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            if (fail_count < 40)
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, what, $signed(want), $signed(got));
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: both channels are sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        bit       made;
        gga_fix_t fx;
        gga_fix_t want;
        if (aresetn && s_valid && s_ready) begin
            parse_rx_byte(s_rx_byte, made, fx);
            if (row_typed) begin
                // typed rows end in exactly one terminator
                if ((s_rx_byte == CHAR_CR || s_rx_byte == CHAR_LF) && row_gives_fix) begin
                    pending_fixes.push_back(row_fix);
                    fixes_made++;
                end
            end else if (made) begin
                pending_fixes.push_back(fx);
                fixes_made++;
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_fixes.size() == 0) begin
                if (fail_count < 40)
                    $display("%0t ns: unexpected fix, expected none, got %0d %0d %0d",
                             $time, m_lat_e7, m_lon_e7, m_alt_cm);
                fail_count++;
            end else begin
                want = pending_fixes.pop_front();
                check_field("lat_e7", want.lat, m_lat_e7);
                check_field("lon_e7", want.lon, m_lon_e7);
                check_field("alt_cm", want.alt, m_alt_cm);
            end
        end
    end

    // ------------------------------------------------------------------
    // fix sink: random backpressure bursts, plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long hold so the parser fills up and stalls its input
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // byte source helpers
    // ------------------------------------------------------------------
    // present one word at the falling edge, hold it until it is taken
    task send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task send_buffer();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
    endtask

    function void push_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            line_buf.push_back(txt[i]);
    endfunction

    function void push_digits(input int n);
        repeat (n)
            line_buf.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
    endfunction

    // hemisphere field: empty, right letter, other letter, or two letters
    function void push_hemi(input string pos_c, input string neg_c);
        case ($urandom_range(0, 9))
            0:       ;
            1:       line_buf.push_back(CHAR_A + 8'($urandom_range(0, 25)));
            2:       push_text({neg_c, pos_c});
            3, 4, 5: push_text(pos_c);
            default: push_text(neg_c);
        endcase
    endfunction

    // signed decimal with occasional empty or huge integer part
    function void push_number(input bit angle);
        int r;
        r = $urandom_range(0, 14);
        if (r == 0)
            push_text("-");
        else if (r == 1)
            push_text("+");
        if ($urandom_range(0, 29) == 0)
            ;
        else if ($urandom_range(0, 14) == 0)
            push_digits($urandom_range(7, 10));
        else
            push_digits(angle ? $urandom_range(3, 5) : $urandom_range(1, 5));
        if ($urandom_range(0, 3) != 0) begin
            push_text(".");
            push_digits($urandom_range(0, 7));
        end
    endfunction

    // gga sentence with random content; lean leaves optional fields empty
    function void build_sentence(input bit lean);
        int fill;
        line_buf.delete();
        push_text($urandom_range(0, 1) ? "$GPGGA," : "$GNGGA,");
        if (!lean)
            push_digits($urandom_range(0, 6));
        push_text(",");
        push_number(1'b1);
        push_text(",");
        push_hemi("N", "S");
        push_text(",");
        push_number(1'b1);
        push_text(",");
        push_hemi("E", "W");
        push_text(",");
        push_digits($urandom_range(1, 2));
        push_text(",");
        if (!lean) begin
            push_digits($urandom_range(0, 2));
            push_text(",");
            push_digits($urandom_range(0, 1));
            push_text(".9,");
        end else begin
            push_text(",,");
        end
        push_number(1'b0);
        if (!lean) begin
            case ($urandom_range(0, 5))
                0, 1: push_text(",M,46.9,M,,*47");
                2:    push_text(",M");
                3: begin
                    // long tail that may push the line past the limit
                    push_text(",");
                    fill = $urandom_range(30, 110);
                    repeat (fill)
                        line_buf.push_back(8'($urandom_range(32, 126)));
                end
                default: ;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       push_text("\r");
            1:       push_text("\n");
            default: push_text("\r\n");
        endcase
        if (!lean && $urandom_range(0, 5) == 0)
            line_buf[$urandom_range(0, line_buf.size() - 2)] = 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // directed rows
    // ------------------------------------------------------------------
    gga_row_t dir_rows[$];

    initial begin
        int       fix_base;
        int       slot;
        gga_row_t row;

        dir_rows = '{
            // empty line does nothing
            '{"\n", 0, -1, 1'b1, 1'b0, '0},
            // textbook sentence
            '{"$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n",
              0, -1, 1'b1, 1'b1, '{32'sd481173000, 32'sd115166666, 32'sd54540}},
            // pole and antimeridian, deepest altitude, south and west
            '{"$GNGGA,,9000.00000,S,18000.00000,W,9,,,-99999.99\n", 0, -1, 1'b1, 1'b1,
              '{-32'sd900000000, -32'sd1800000000, -32'sd9999999}},
            // saturated accumulators and clamped output
            '{"$GPGGA,,99999999.99999,S,99999999,W,1,,,99999999\r", 0, -1, 1'b1, 1'b1,
              '{-32'sd2147483647, -32'sd2147483647, 32'sd1677721500}},
            // minus sign cancels against s, negative zero, sub-metre altitude
            '{"$GPGGA,,-4500.5,S,-00000,E,3,,,-0.5\n", 0, -1, 1'b1, 1'b1,
              '{32'sd450083333, 32'sd0, -32'sd50}},
            // all zero coordinates and altitude
            '{"$GPGGA,,0000,N,00000,E,1,,,0\n", 0, -1, 1'b1, 1'b1, '0},
            // fraction-only altitude
            '{"$GPGGA,,1,,1,,1,,,.5\n", 0, -1, 1'b1, 1'b1,
              '{32'sd166666, 32'sd166666, 32'sd50}},
            // extra fraction digits dropped
            '{"$GNGGA,,0059.9999999,S,00059.9999999,W,2,,,12.345\n", 0, -1, 1'b1, 1'b1,
              '{-32'sd9999998, -32'sd9999998, 32'sd1234}},
            // fix quality zero
            '{"$GPGGA,,4807.038,N,01131.000,E,0,08,0.9,545.4\n", 0, -1, 1'b1, 1'b0, '0},
            // point in fix quality
            '{"$GPGGA,,4807,N,01131,E,1.0,,,5\n", 0, -1, 1'b1, 1'b0, '0},
            // sign in fix quality
            '{"$GPGGA,,4807,N,01131,E,+1,,,5\n", 0, -1, 1'b1, 1'b0, '0},
            // empty latitude
            '{"$GPGGA,,,N,01131,E,1,,,5\n", 0, -1, 1'b1, 1'b0, '0},
            // letter inside latitude
            '{"$GPGGA,,48a7,N,01131,E,1,,,5\n", 0, -1, 1'b1, 1'b0, '0},
            // two decimal points
            '{"$GPGGA,,48.0.7,N,01131,E,1,,,5\n", 0, -1, 1'b1, 1'b0, '0},
            // sign after digits
            '{"$GPGGA,,4807,N,011-31,E,1,,,5\n", 0, -1, 1'b1, 1'b0, '0},
            // ends before altitude field
            '{"$GPGGA,,4807,N,01131,E,1,08,0.9\n", 0, -1, 1'b1, 1'b0, '0},
            // empty altitude
            '{"$GPGGA,,1,,1,,1,,,\n", 0, -1, 1'b1, 1'b0, '0},
            // wrong sentence type
            '{"$GPGSA,,1,,1,,1,,,1\n", 0, -1, 1'b1, 1'b0, '0},
            // nul byte inside latitude
            '{"$GPGGA,,1,,1,,1,,,1\n", 0, 8, 1'b1, 1'b0, '0},
            // line hits the limit on its dollar sign, remainder is garbage
            '{"$GPGGA,,1,,1,,1,,,1\n", 126, -1, 1'b1, 1'b0, '0},
            // limit reached by junk, next byte starts a clean line
            '{"$GPGGA,,1,,1,,1,,,1\n", 127, -1, 1'b0, 1'b0, '0},
            // hemisphere letters after the first ignored, text in ignored fields
            '{"$GPGGA,,1,NS,1,XW,1,hello,x,1\r\n", 0, -1, 1'b0, 1'b0, '0},
            // plus signs, lower-case hemisphere, trailing empty fields
            '{"$GNGGA,123,+3000,s,+04500,w,1,,,+7,,,,,,,,\n", 0, -1, 1'b0, 1'b0, '0}
        };

        pending_fixes.delete();
        fixes_made = 0;
        fail_count = 0;
        bytes_sent = 0;
        row_typed  = 1'b0;
        hold_req   = 1'b0;
        gaps_on    = 1'b1;
        clear_line();
        lat_hold = '0;
        lon_hold = '0;
        alt_hold = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            line_buf.delete();
            repeat (row.pad)
                push_text("x");
            push_text(row.text);
            if (row.nul_at >= 0)
                line_buf[row.pad + row.nul_at] = CHAR_NUL;
            row_typed     = row.typed;
            row_gives_fix = row.gives_fix;
            row_fix       = row.fix;
            send_buffer();
        end
        row_typed = 1'b0;

        // sink holds off while a run of short random sentences keeps coming
        hold_req = 1'b1;
        repeat (12) begin
            build_sentence(1'b1);
            send_buffer();
        end

        // random part: mostly sentences, some raw noise, idling toggled in stretches
        fix_base   = fixes_made;
        bytes_sent = 0;
        slot       = 0;
        while (bytes_sent < RAND_BYTES || fixes_made - fix_base < RAND_FIXES) begin
            if (slot % 10 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 19) < 15) begin
                build_sentence(1'b0);
            end else begin
                line_buf.delete();
                repeat ($urandom_range(1, 40))
                    line_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                    push_text("\n");
            end
            send_buffer();
            slot++;
        end

        // closing stretch at full rate
        gaps_on = 1'b0;
        repeat (6) begin
            build_sentence(1'b0);
            send_buffer();
        end
        s_valid <= 1'b0;

        while (pending_fixes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== nmea_gga_fix_parser_core.f =====
rtl/ngga_pkg.sv
rtl/ngga_lexer.sv
rtl/ngga_angle_conv.sv
rtl/nmea_gga_fix_parser_core.sv
tb/tb_top.sv
